@@ hdl/fcr_pkg.sv @@
// Shared types and constants for the FAT chain reader and freer.
package fcr_pkg;

    // Command codes carried on the slave-side tuser.
    typedef enum logic [2:0] {
        CMD_WR_TABLE = 3'd0,
        CMD_WR_DATA  = 3'd1,
        CMD_OPEN     = 3'd2,
        CMD_NEXT     = 3'd3,
        CMD_FREE     = 3'd4
    } t_cmd;

    // Result status carried on the master-side tuser.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LINK   = 2'd1,
        ST_WALK_LIMIT = 2'd2
    } t_status;

    // Configuration register indexes.
    typedef enum logic {
        CFG_BLOCK_SIZE    = 1'b0,
        CFG_TABLE_ENTRIES = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] END_MARK    = 8'hFF;
    localparam int         STORE_AW    = 12;
    localparam int         STORE_DEPTH = 4096;
    localparam int         IN_DATA_W   = 48;
    localparam int         OUT_DATA_W  = 24;
    localparam int         CFG_DATA_W  = 9;

endpackage

@@ hdl/fat_chain_reader_freer.sv @@
// FAT-style chain walker: link table, byte store, read cursor and chain free.
//
// The block keeps a link table (TABLE_DEPTH entries of 8 bits, 1-based next
// block, 0 free, 0xFF end of chain) and a 4096-byte store, both in
// single-port-read synchronous RAMs that the user loads beat by beat with
// the write commands; neither is cleared after reset, so an entry must be
// written before it is read. Open points the cursor at a chain, next byte
// returns store[block*block_size+offset] and follows the link when a block
// is used up, free zeroes a chain entry by entry and reports the count.
// Table write, data write and open return no result beat. Next byte reads
// the store directly inside a block; on a block boundary it reads the link
// from the table RAM first and then the store, and it returns status 1
// without any RAM read when the cursor block lies outside the table in use.
// Free reads one table entry per step, since every link has to come back
// from the table RAM before the next address is known. The input side takes
// a new beat only while no command is in flight and no configuration write
// is offered; the result sits in an output register, so the next beat can
// enter while it waits. Configuration writes are taken only while no command
// is in flight, and win over a command beat offered in the same cycle.
// Block size is used clamped to 1..MAX_BLOCK_BYTES, table_entries to
// TABLE_DEPTH. A next byte whose link is bad returns status 1 and leaves the
// cursor alone; a free walk stops with status 1 on a bad link and status 2
// once it has zeroed table_entries entries.
module fat_chain_reader_freer #(
    parameter int TABLE_DEPTH     = 256,
    parameter int MAX_BLOCK_BYTES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] table_index, [15:8] entry_value, [27:16] data_address,
    // [35:28] data_byte, [43:36] first_block, [47:44] zero
    input  logic [fcr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [2:0] command
    input  logic [2:0]                      i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] read_byte, [16:8] freed_count, [23:17] zero
    output logic [fcr_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // [1:0] status
    output logic [1:0]                      o_m_tuser,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [fcr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import fcr_pkg::*;

    localparam int         TAW    = $clog2(TABLE_DEPTH);
    localparam logic [8:0] LP_TD  = 9'(TABLE_DEPTH);
    localparam logic [8:0] LP_MAXB = 9'(MAX_BLOCK_BYTES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LINK   = 4'b0010,
        S_FREE   = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    // control state
    t_state      r_state,        n_state;
    logic [4:0]  r_block_size;
    logic [8:0]  r_table_entries;
    logic [7:0]  r_cursor_block, n_cursor_block;
    logic [4:0]  r_cursor_offset, n_cursor_offset;
    logic        r_m_valid,      n_m_valid;
    // walk and result holding
    logic [7:0]  r_cur,          n_cur;
    logic [8:0]  r_freed,        n_freed;
    logic        r_fwd,          n_fwd;
    t_status     r_res_status,   n_res_status;
    logic        r_res_data,     n_res_data;
    logic [8:0]  r_res_freed,    n_res_freed;
    // output payload
    logic [7:0]  r_m_read_byte,  n_m_read_byte;
    logic [8:0]  r_m_freed,      n_m_freed;
    t_status     r_m_status,     n_m_status;

    // decoded beat
    t_cmd        s_cmd;
    logic [7:0]  s_tidx, s_tval, s_dbyte, s_first;
    logic [11:0] s_daddr;

    // effective configuration
    logic [4:0]  bs_eff;
    logic [8:0]  entries;

    // memory ports
    logic           tbl_we, tbl_re;
    logic [TAW-1:0] tbl_waddr, tbl_raddr;
    logic [7:0]     tbl_wdata, tbl_rdata;
    logic                dat_we, dat_re;
    logic [STORE_AW-1:0] dat_waddr, dat_raddr;
    logic [7:0]          dat_wdata, dat_rdata;

    // datapath helpers
    logic        accept, out_free, need_link;
    logic [12:0] addr_cur, addr_link;
    logic [7:0]  link_v, link_blk;
    logic [8:0]  freed_inc;

    assign s_cmd   = t_cmd'(i_s_tuser);
    assign s_tidx  = i_s_tdata[7:0];
    assign s_tval  = i_s_tdata[15:8];
    assign s_daddr = i_s_tdata[27:16];
    assign s_dbyte = i_s_tdata[35:28];
    assign s_first = i_s_tdata[43:36];

    always_comb begin
        if (r_block_size == 5'd0) begin
            bs_eff = 5'd1;
        end else if ({4'd0, r_block_size} > LP_MAXB) begin
            bs_eff = LP_MAXB[4:0];
        end else begin
            bs_eff = r_block_size;
        end
        entries = (r_table_entries > LP_TD) ? LP_TD : r_table_entries;
    end

    // a pending register write goes first, the command beat follows it
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_valid || i_m_tready;
    assign need_link   = (r_cursor_offset >= bs_eff);

    // store addresses wrap to 12 bits
    assign addr_cur  = 13'(r_cursor_block) * 13'(bs_eff) + 13'(r_cursor_offset);
    assign link_blk  = tbl_rdata - 8'd1;
    assign addr_link = 13'(link_blk) * 13'(bs_eff);

    // a link read in the same cycle as the zeroing write of that entry reads 0
    assign link_v    = r_fwd ? 8'd0 : tbl_rdata;
    assign freed_inc = r_freed + 9'd1;

    always_comb begin
        n_state         = r_state;
        n_cursor_block  = r_cursor_block;
        n_cursor_offset = r_cursor_offset;
        n_m_valid       = r_m_valid;
        n_cur           = r_cur;
        n_freed         = r_freed;
        n_fwd           = r_fwd;
        n_res_status    = r_res_status;
        n_res_data      = r_res_data;
        n_res_freed     = r_res_freed;
        n_m_read_byte   = r_m_read_byte;
        n_m_freed       = r_m_freed;
        n_m_status      = r_m_status;
        tbl_we    = 1'b0;
        tbl_waddr = s_tidx[TAW-1:0];
        tbl_wdata = s_tval;
        tbl_re    = 1'b0;
        tbl_raddr = r_cursor_block[TAW-1:0];
        dat_we    = 1'b0;
        dat_waddr = s_daddr;
        dat_wdata = s_dbyte;
        dat_re    = 1'b0;
        dat_raddr = addr_cur[STORE_AW-1:0];

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        CMD_WR_TABLE: begin
                            tbl_we = ({1'b0, s_tidx} < LP_TD);
                        end
                        CMD_WR_DATA: begin
                            dat_we = 1'b1;
                        end
                        CMD_OPEN: begin
                            n_cursor_block  = s_first - 8'd1;
                            n_cursor_offset = 5'd0;
                        end
                        CMD_NEXT: begin
                            n_res_freed = 9'd0;
                            if (!need_link) begin
                                dat_re          = 1'b1;
                                n_cursor_offset = r_cursor_offset + 5'd1;
                                n_res_status    = ST_OK;
                                n_res_data      = 1'b1;
                                n_state         = S_RESULT;
                            end else if ({1'b0, r_cursor_block} >= entries) begin
                                n_res_status = ST_BAD_LINK;
                                n_res_data   = 1'b0;
                                n_state      = S_RESULT;
                            end else begin
                                tbl_re  = 1'b1;
                                n_state = S_LINK;
                            end
                        end
                        CMD_FREE: begin
                            n_res_data  = 1'b0;
                            n_res_freed = 9'd0;
                            n_freed     = 9'd0;
                            n_fwd       = 1'b0;
                            n_cur       = s_first - 8'd1;
                            if (s_first == 8'd0) begin
                                n_res_status = ST_BAD_LINK;
                                n_state      = S_RESULT;
                            end else if (s_first == END_MARK) begin
                                // empty chain
                                n_res_status = ST_OK;
                                n_state      = S_RESULT;
                            end else if ({1'b0, s_first - 8'd1} >= entries) begin
                                n_res_status = ST_BAD_LINK;
                                n_state      = S_RESULT;
                            end else begin
                                tbl_re    = 1'b1;
                                tbl_raddr = n_cur[TAW-1:0];
                                n_state   = S_FREE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LINK: begin
                if (tbl_rdata == 8'd0 || tbl_rdata == END_MARK ||
                    {1'b0, link_blk} >= entries) begin
                    n_res_status = ST_BAD_LINK;
                    n_res_data   = 1'b0;
                end else begin
                    n_cursor_block  = link_blk;
                    n_cursor_offset = 5'd1;
                    dat_re          = 1'b1;
                    dat_raddr       = addr_link[STORE_AW-1:0];
                    n_res_status    = ST_OK;
                    n_res_data      = 1'b1;
                end
                n_state = S_RESULT;
            end
            S_FREE: begin
                tbl_we      = 1'b1;
                tbl_waddr   = r_cur[TAW-1:0];
                tbl_wdata   = 8'd0;
                n_freed     = freed_inc;
                n_res_freed = freed_inc;
                n_state     = S_RESULT;
                if (link_v == 8'd0) begin
                    n_res_status = ST_BAD_LINK;
                end else if (link_v == END_MARK) begin
                    n_res_status = ST_OK;
                end else if ({1'b0, link_v - 8'd1} >= entries) begin
                    n_res_status = ST_BAD_LINK;
                end else if (freed_inc >= entries) begin
                    n_res_status = ST_WALK_LIMIT;
                end else begin
                    n_cur     = link_v - 8'd1;
                    n_fwd     = ((link_v - 8'd1) == r_cur);
                    tbl_re    = 1'b1;
                    tbl_raddr = n_cur[TAW-1:0];
                    n_state   = S_FREE;
                end
            end
            S_RESULT: begin
                // store data, if any, is on the RAM output this cycle
                if (out_free) begin
                    n_m_valid     = 1'b1;
                    n_m_read_byte = r_res_data ? dat_rdata : 8'd0;
                    n_m_freed     = r_res_freed;
                    n_m_status    = r_res_status;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_block_size    <= 5'd4;
            r_table_entries <= 9'd256;
            r_cursor_block  <= 8'd0;
            r_cursor_offset <= 5'd0;
            r_m_valid       <= 1'b0;
            r_fwd           <= 1'b0;
            r_freed         <= 9'd0;
            r_cur           <= 8'd0;
        end else begin
            r_state         <= n_state;
            r_cursor_block  <= n_cursor_block;
            r_cursor_offset <= n_cursor_offset;
            r_m_valid       <= n_m_valid;
            r_fwd           <= n_fwd;
            r_freed         <= n_freed;
            r_cur           <= n_cur;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BLOCK_SIZE:    r_block_size    <= i_cfg_data[4:0];
                    CFG_TABLE_ENTRIES: r_table_entries <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status  <= n_res_status;
        r_res_data    <= n_res_data;
        r_res_freed   <= n_res_freed;
        r_m_read_byte <= n_m_read_byte;
        r_m_freed     <= n_m_freed;
        r_m_status    <= n_m_status;
    end

    fcr_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    fcr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (dat_wdata),
        .i_re    (dat_re),
        .i_raddr (dat_raddr),
        .o_rdata (dat_rdata)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m_freed, r_m_read_byte};
    assign o_m_tuser  = r_m_status;

    // walk address is always inside the table in use
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |-> ({1'b0, r_cur} < entries))
        else $error("free walk outside table");

    // the walk stops before it has zeroed more entries than are in use
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |-> (r_freed < entries))
        else $error("free walk count overrun");

    // a new result beat comes only from the result state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !$past(o_m_tvalid)) |-> $past(r_state == S_RESULT))
        else $error("result loaded outside result state");

    // a held result blocks the next one instead of overwriting it
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && !out_free) |=> (r_state == S_RESULT))
        else $error("result state left with output full");

endmodule

@@ hdl/fcr_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
module fcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the FAT chain reader and freer block.
module tb_top;
    import fcr_pkg::*;

    localparam int          QUIET_LIMIT = 3000;  // cycles with no beat moving on any port
    localparam int          SETTLE      = 8;     // slack after the last result
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 130;
    localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int          MAX_NOTES   = 30;
    localparam logic [2:0]  CMD_FIRST_UNUSED = 3'd5;

    // One command beat, fields as they sit on the slave side.
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  tidx;
        logic [7:0]  tval;
        logic [11:0] daddr;
        logic [7:0]  dbyte;
        logic [7:0]  first;
    } t_fat_cmd;

    // One result beat as the master side should present it.
    typedef struct packed {
        logic [7:0] rbyte;
        logic [8:0] freed;
        t_status    st;
    } t_fat_res;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata   = '0;
    logic [2:0]             i_s_tuser   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic [1:0]             o_m_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Predictor state: shadow of the table, the store, the cursor and the registers.
    logic [7:0] shadow_links [256];
    logic [7:0] shadow_bytes [STORE_DEPTH];
    bit         byte_set     [STORE_DEPTH];  // store locations already written
    logic [7:0] rd_blk      = 8'd0;
    logic [4:0] rd_off      = 5'd0;
    logic [4:0] cfg_bsize   = 5'd4;
    logic [8:0] cfg_entries = 9'd256;

    t_fat_cmd cmd_queue [$];     // beats waiting for the driver
    t_fat_res want_results [$];  // results predicted, not yet seen
    t_fat_cmd held_cmd;

    int gap_left   = 0;
    int burst_left = 8;
    int hold_left  = 0;
    int rx_mode    = 0;
    int rx_cyc     = 0;
    int n_results  = 0;
    int err_cnt    = 0;
    int quiet_cyc  = 0;

    fat_chain_reader_freer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Register values as the block uses them: block size clamped to 1..16,
    // entry count clamped to the table depth (0 leaves every link bad).
    function automatic int eff_bsize(logic [4:0] raw);
        if (raw == 5'd0) return 1;
        if (raw > 5'd16) return 16;
        return raw;
    endfunction

    function automatic int eff_entries(logic [8:0] raw);
        return (raw > 9'd256) ? 256 : raw;
    endfunction

    // Store address the next byte command would read from the present shadow
    // state, or -1 when it fails on a bad link.
    function automatic int next_read_addr();
        int bs, ents, v, blk, off;
        bs   = eff_bsize(cfg_bsize);
        ents = eff_entries(cfg_entries);
        blk  = rd_blk;
        off  = rd_off;
        if (off >= bs) begin
            v = (blk < ents) ? shadow_links[blk] : 0;
            if (blk >= ents || v == 0 || v == END_MARK || v - 1 >= ents) return -1;
            blk = v - 1;
            off = 0;
        end
        return (blk * bs + off) % STORE_DEPTH;
    endfunction

    task automatic queue_cmd(t_fat_cmd c);
        cmd_queue = {cmd_queue, c};
    endtask

    // Advance the shadow state by one accepted beat and queue any result it owes.
    task automatic walk_predict(t_fat_cmd c);
        int       bs, ents, v, cur, freed, addr;
        bit       ok, walking;
        t_status  st;
        t_fat_res res;
        bs   = eff_bsize(cfg_bsize);
        ents = eff_entries(cfg_entries);
        res  = '0;
        st   = ST_OK;
        case (c.op)
            CMD_WR_TABLE: shadow_links[c.tidx] = c.tval;
            CMD_WR_DATA: begin
                shadow_bytes[c.daddr] = c.dbyte;
                byte_set[c.daddr]     = 1'b1;
            end
            CMD_OPEN: begin
                rd_blk = c.first - 8'd1;   // first block 0 wraps to 255
                rd_off = 5'd0;
            end
            CMD_NEXT: begin
                // block used up: follow the link, or fail and leave the cursor
                if (rd_off >= bs) begin
                    v = (rd_blk < ents) ? shadow_links[rd_blk] : 0;
                    if (rd_blk >= ents || v == 0 || v == END_MARK || v - 1 >= ents) begin
                        st = ST_BAD_LINK;
                    end else begin
                        rd_blk = 8'(v - 1);
                        rd_off = 5'd0;
                    end
                end
                if (st == ST_OK) begin
                    addr      = (rd_blk * bs + rd_off) % STORE_DEPTH;
                    res.rbyte = shadow_bytes[addr];
                    rd_off    = rd_off + 5'd1;
                end
                res.st = st;
                want_results = {want_results, res};
            end
            CMD_FREE: begin
                ok      = (c.first != 8'd0);
                cur     = ok ? c.first - 1 : 0;
                freed   = 0;
                walking = 1'b1;
                while (walking) begin
                    if (!ok) begin
                        st      = ST_BAD_LINK;
                        walking = 1'b0;
                    end else if (cur + 1 == END_MARK) begin
                        walking = 1'b0;           // empty chain or end reached
                    end else if (cur >= ents) begin
                        st      = ST_BAD_LINK;
                        walking = 1'b0;
                    end else if (freed >= ents) begin
                        st      = ST_WALK_LIMIT;
                        walking = 1'b0;
                    end else begin
                        v                 = shadow_links[cur];
                        shadow_links[cur] = 8'd0;
                        freed++;
                        if (v == 0) ok = 1'b0;
                        else cur = v - 1;
                    end
                end
                res.freed = 9'(freed);
                res.st    = st;
                want_results = {want_results, res};
            end
            default: ;  // unused codes are dropped by the block
        endcase
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers: every field random, then the meaningful ones set.
    // ---------------------------------------------------------------
    function automatic t_fat_cmd rand_cmd();
        t_fat_cmd c;
        c.op    = 3'($urandom_range(0, 7));
        c.tidx  = 8'($urandom);
        c.tval  = 8'($urandom);
        c.daddr = 12'($urandom);
        c.dbyte = 8'($urandom);
        c.first = 8'($urandom);
        return c;
    endfunction

    task automatic add_link(int idx, int val);
        t_fat_cmd c;
        c      = rand_cmd();
        c.op   = CMD_WR_TABLE;
        c.tidx = 8'(idx);
        c.tval = 8'(val);
        queue_cmd(c);
    endtask

    task automatic add_byte(int addr, int val);
        t_fat_cmd c;
        c       = rand_cmd();
        c.op    = CMD_WR_DATA;
        c.daddr = 12'(addr);
        c.dbyte = 8'(val);
        queue_cmd(c);
    endtask

    task automatic add_open(int blk1);
        t_fat_cmd c;
        c       = rand_cmd();
        c.op    = CMD_OPEN;
        c.first = 8'(blk1);
        queue_cmd(c);
    endtask

    task automatic add_next(int count);
        t_fat_cmd c;
        repeat (count) begin
            c    = rand_cmd();
            c.op = CMD_NEXT;
            queue_cmd(c);
        end
    endtask

    task automatic add_free(int blk1);
        t_fat_cmd c;
        c       = rand_cmd();
        c.op    = CMD_FREE;
        c.first = 8'(blk1);
        queue_cmd(c);
    endtask

    // A well-formed chain over distinct in-range blocks, then a read through
    // it and/or a free of it. The tail is mostly the end marker, sometimes a
    // loop back into the chain (walk limit when it covers every entry), a
    // free entry or a link past the entries in use. Blocks 254 and 255 can
    // never be link targets (values 0xFF and 0x100), so they stay out.
    task automatic plan_chain(int bs_e, int en_e);
        int pool [254];
        int lim, n, len, j, tmp, nrd, tail;
        lim = (en_e > 0) ? en_e : 8;
        n   = (lim < 254) ? lim : 254;
        for (int b = 0; b < n; b++) pool[b] = b;
        if (n <= 24 && $urandom_range(0, 3) == 0) len = n;
        else len = $urandom_range(1, (n < 12) ? n : 12);
        for (int i = 0; i < len; i++) begin
            j       = $urandom_range(i, n - 1);
            tmp     = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        for (int i = 0; i + 1 < len; i++) add_link(pool[i], pool[i + 1] + 1);
        case ($urandom_range(0, 7))
            0, 1:    tail = pool[$urandom_range(0, len - 1)] + 1;
            2:       tail = (en_e < 254) ? $urandom_range(en_e + 1, 254) : 0;
            3:       tail = 0;
            default: tail = END_MARK;
        endcase
        add_link(pool[len - 1], tail);
        repeat ($urandom_range(0, 2))
            add_byte(pool[$urandom_range(0, len - 1)] * bs_e + $urandom_range(0, bs_e - 1),
                     $urandom);
        if ($urandom_range(0, 3) != 0) begin
            add_open(pool[0] + 1);
            nrd = $urandom_range(1, len * bs_e + 2);
            if (nrd > 40) nrd = $urandom_range(20, 40);
            add_next(nrd);
        end
        if ($urandom_range(0, 1) == 1)
            add_free(pool[($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : 0] + 1);
    endtask

    // Register write on the config channel; the shadow copy follows at the
    // handshake edge.
    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_BLOCK_SIZE) cfg_bsize = val[4:0];
        else cfg_entries = val;
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued beat has gone in and every result has come out.
    task automatic drain();
        while (cmd_queue.size() != 0 || i_s_tvalid || want_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic note_mismatch(string what, int got, int want);
        if (err_cnt < MAX_NOTES)
            $display("ERROR result %0d: %s got %0d want %0d", n_results, what, got, want);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of random length with random gaps; the shadow model
    // steps on each accepted beat. The shadow is exact whenever a beat is
    // chosen, so a next byte that would land on an unwritten store location
    // is preceded by a data write to that location.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        int rd_addr;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) walk_predict(held_cmd);
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    rd_addr = next_read_addr();
                    if (cmd_queue[0].op == CMD_NEXT && rd_addr >= 0 && !byte_set[rd_addr]) begin
                        held_cmd       = rand_cmd();
                        held_cmd.op    = CMD_WR_DATA;
                        held_cmd.daddr = 12'(rd_addr);
                    end else begin
                        held_cmd = cmd_queue.pop_front();
                    end
                    i_s_tdata  <= {4'd0, held_cmd.first, held_cmd.dbyte, held_cmd.daddr,
                                   held_cmd.tval, held_cmd.tidx};
                    i_s_tuser  <= held_cmd.op;
                    i_s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result beat against the oldest prediction and
    // drives tready on its own stall pattern. Twice in the run it holds off
    // for a long stretch so the block backs up and stalls its input.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fat_res exp_r;
        logic     rdy;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                n_results++;
                if (want_results.size() == 0) begin
                    note_mismatch("result with nothing expected, tdata", o_m_tdata, 0);
                end else begin
                    exp_r = want_results.pop_front();
                    if (o_m_tdata[7:0] !== exp_r.rbyte)
                        note_mismatch("read_byte", o_m_tdata[7:0], exp_r.rbyte);
                    if (o_m_tdata[16:8] !== exp_r.freed)
                        note_mismatch("freed_count", o_m_tdata[16:8], exp_r.freed);
                    if (o_m_tuser !== exp_r.st)
                        note_mismatch("status", o_m_tuser, exp_r.st);
                end
                if (n_results == 60 || n_results == 400) hold_left = HOLD_CYCLES;
            end
            rx_cyc++;
            if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 3) != 0);
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = rx_cyc[0];
            endcase
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= rdy;
            end
        end
    end

    // Watchdog: cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
    end

    initial begin
        wait (quiet_cyc >= QUIET_LIMIT);
        $display("fat_chain_reader_freer test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sequence: reset, table load, directed corner cases, then random phases
    // each under its own register setting.
    // ---------------------------------------------------------------
    initial begin
        int         perm [254];
        int         j, tmp, bs_e, en_e;
        logic [4:0] bs_raw;
        logic [8:0] en_raw;
        t_fat_cmd   c;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load: the table becomes one loop through blocks 0..253 in shuffled
        // order, entries 254/255 random. Store bytes are written by the
        // driver just before a read would first reach them.
        for (int i = 0; i < 254; i++) perm[i] = i;
        for (int i = 253; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < 254; i++) add_link(perm[i], perm[(i + 1) % 254] + 1);
        add_link(254, $urandom);
        add_link(255, $urandom);

        // Directed, reset setting (block size 4, all 256 entries).
        for (int k = CMD_FIRST_UNUSED; k <= 7; k++) begin
            c    = rand_cmd();
            c.op = 3'(k);
            queue_cmd(c);
        end
        add_free(0);              // bad start block
        add_free(END_MARK);       // empty chain
        add_open(0);              // cursor wraps to block 255
        add_next(5);              // fifth beat follows the link out of 255
        add_free(1);              // whole loop, ends on an entry it zeroed itself
        add_link(3, END_MARK);
        add_open(4);
        add_next(5);              // fifth beat meets the end marker
        add_free(4);              // one-entry chain ending cleanly
        add_free(8);              // entry already free
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin bs_raw = 5'd16; en_raw = 9'd256; end
                1: begin bs_raw = 5'd1;  en_raw = 9'd1;   end
                2: begin bs_raw = 5'd0;  en_raw = 9'd0;   end
                3: begin bs_raw = 5'd31; en_raw = 9'd511; end
                4: begin bs_raw = 5'd2;  en_raw = 9'd5;   end
                5: begin bs_raw = 5'd9;  en_raw = 9'd3;   end
                default: begin
                    bs_raw = 5'($urandom_range(0, 31));
                    en_raw = 9'($urandom_range(1, 40));
                end
            endcase
            // upper data bits on the block size write are junk the block masks off
            cfg_write(CFG_BLOCK_SIZE, {4'($urandom), bs_raw});
            cfg_write(CFG_TABLE_ENTRIES, en_raw);
            bs_e = eff_bsize(bs_raw);
            en_e = eff_entries(en_raw);
            while (cmd_queue.size() < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    plan_chain(bs_e, en_e);
                end else begin
                    repeat ($urandom_range(1, 4)) queue_cmd(rand_cmd());
                end
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("fat_chain_reader_freer test passed");
        end else begin
            $display("fat_chain_reader_freer test failed");
        end
        $finish;
    end

endmodule
